@@ rtl/klsd_pkg.sv @@
package klsd_pkg;

  localparam int ACT_BITS     = 2;
  localparam int IN_KEY_BITS  = 64;
  localparam int PRICE_BITS   = 32;
  localparam int QTY_BITS     = 32;
  localparam int POS_BITS     = 7;
  localparam int STATUS_BITS  = 2;
  localparam int IDX_OUT_BITS = 7;
  localparam int TOTAL_BITS   = 8;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } fsm_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic wr;
    logic shift;
    logic by_key;
  } cell_ctrl_t;

endpackage

@@ rtl/klsd_if.sv @@
interface klsd_in_if;
  logic                                valid;
  logic                                ready;
  logic [klsd_pkg::ACT_BITS-1:0]       action;
  logic [klsd_pkg::IN_KEY_BITS-1:0]    key;
  logic [klsd_pkg::PRICE_BITS-1:0]     price_cents;
  logic signed [klsd_pkg::QTY_BITS-1:0] stock_qty;
  logic [klsd_pkg::POS_BITS-1:0]       position;

  modport source(output valid, action, key, price_cents, stock_qty, position, input ready);
  modport sink(input valid, action, key, price_cents, stock_qty, position, output ready);
endinterface

interface klsd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [klsd_pkg::STATUS_BITS-1:0]     status;
  logic [klsd_pkg::IDX_OUT_BITS-1:0]    found_index;
  logic [klsd_pkg::PRICE_BITS-1:0]      found_price;
  logic signed [klsd_pkg::QTY_BITS-1:0] found_qty;
  logic [klsd_pkg::TOTAL_BITS-1:0]      entry_total;

  modport source(output valid, status, found_index, found_price, found_qty, entry_total,
                 input ready);
  modport sink(input valid, status, found_index, found_price, found_qty, entry_total,
               output ready);
endinterface

@@ rtl/keyed_list_insert_search_delete_unit.sv @@
// insert and the unused action code: accept goes straight to the finish step, which loads the result word
// search and delete: pass through the run step while the hit climbs the registered
//   first-hit tree that sits behind the row of cells, then load the result word
// one word in flight; the next word is taken once the current one has finished
// reset (rst_n low, synchronous) clears the entry count, sequencer and result valid;
//   entry storage is not cleared, no sweep after reset
module keyed_list_insert_search_delete_unit #(
  parameter int CAPACITY = 128,
  parameter int KEY_BITS = 64
) (
  input logic       clk,
  input logic       rst_n,
  klsd_in_if.sink   in_ch,
  klsd_out_if.source out_ch
);
  import klsd_pkg::*;

  localparam int IDXW = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int LVL  = IDXW;
  localparam int RCW  = $clog2(LVL + 1);

  // sequencer state
  fsm_t           state_r, state_nxt;
  logic [RCW-1:0] run_cnt_r;
  logic [CNTW-1:0] cnt_r;

  // latched word
  action_t               op_act_r;
  logic [KEY_BITS-1:0]   op_key_r;
  logic [PRICE_BITS-1:0] op_price_r;
  logic [QTY_BITS-1:0]   op_qty_r;
  logic [POS_BITS-1:0]   op_pos_r;

  // result register
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [IDX_OUT_BITS-1:0] out_idx_r;
  logic [PRICE_BITS-1:0]   out_price_r;
  logic [QTY_BITS-1:0]     out_qty_r;
  logic [TOTAL_BITS-1:0]   out_total_r;

  logic       in_ready;
  logic       fire;
  logic       full;
  logic       pos_ok;
  cell_ctrl_t ctrl;

  status_t               res_status;
  logic [31:0]           res_idx;
  logic [PRICE_BITS-1:0] res_price;
  logic [QTY_BITS-1:0]   res_qty;
  logic [31:0]           res_total;
  logic [CNTW-1:0]       cnt_nxt;

  // row of cells
  logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
  logic [PRICE_BITS-1:0] cell_price [CAPACITY];
  logic [QTY_BITS-1:0]   cell_qty   [CAPACITY];
  logic [CAPACITY-1:0]   cell_hit;

  logic                  root_hit;
  logic [IDXW-1:0]       root_idx;
  logic [PRICE_BITS-1:0] root_price;
  logic [QTY_BITS-1:0]   root_qty;

  assign full   = (cnt_r == CNTW'(CAPACITY));
  assign pos_ok = (32'(op_pos_r) < 32'(cnt_r));
  // a finished word may leave only when the result register is free
  assign fire   = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    // the top cell shifts in its own contents, they lie above the count anyway
    localparam int NB = (i + 1 < CAPACITY) ? i + 1 : i;
    klsd_cell #(
      .CELL_IDX(i),
      .KEY_BITS(KEY_BITS),
      .CNTW    (CNTW)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .op_key  (op_key_r),
      .op_price(op_price_r),
      .op_qty  (op_qty_r),
      .op_pos  (op_pos_r),
      .count   (cnt_r),
      .nb_key  (cell_key[NB]),
      .nb_price(cell_price[NB]),
      .nb_qty  (cell_qty[NB]),
      .key_r   (cell_key[i]),
      .price_r (cell_price[i]),
      .qty_r   (cell_qty[i]),
      .hit     (cell_hit[i])
    );
  end

  // first hit among the cells, lowest index wins
  klsd_tree #(
    .CAPACITY(CAPACITY),
    .IDXW    (IDXW)
  ) u_tree (
    .clk       (clk),
    .leaf_hit  (cell_hit),
    .leaf_price(cell_price),
    .leaf_qty  (cell_qty),
    .root_hit  (root_hit),
    .root_idx  (root_idx),
    .root_price(root_price),
    .root_qty  (root_qty)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if ((in_ch.action == ACT_SEARCH) || (in_ch.action == ACT_DELETE)) begin
            state_nxt = S_RUN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_RUN: begin
        // tree root holds the answer once the leaves have loaded and the hit has climbed every node level
        if (run_cnt_r == RCW'(LVL)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer and the result of the finishing word
  always_comb begin
    in_ready    = (state_r == S_IDLE);
    ctrl.by_key = (op_act_r == ACT_SEARCH);
    ctrl.wr     = 1'b0;
    ctrl.shift  = 1'b0;
    res_status  = ST_OK;
    res_idx     = '0;
    res_price   = '0;
    res_qty     = '0;
    cnt_nxt     = cnt_r;
    case (op_act_r)
      ACT_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          ctrl.wr   = fire;
          res_idx   = 32'(cnt_r);
          res_price = op_price_r;
          res_qty   = op_qty_r;
          cnt_nxt   = cnt_r + CNTW'(1);
        end
      end
      ACT_SEARCH: begin
        if (root_hit) begin
          res_idx   = 32'(root_idx);
          res_price = root_price;
          res_qty   = root_qty;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      ACT_DELETE: begin
        if (pos_ok) begin
          // the tree picked the cell at the position; the shift follows at fire
          ctrl.shift = fire;
          res_idx    = 32'(op_pos_r);
          res_price  = root_price;
          res_qty    = root_qty;
          cnt_nxt    = cnt_r - CNTW'(1);
        end else begin
          res_status = ST_BAD_INDEX;
        end
      end
      default: begin
      end
    endcase
    res_total = 32'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_cnt_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      op_act_r    <= ACT_NOP;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_RUN) begin
        run_cnt_r <= run_cnt_r + RCW'(1);
      end else begin
        run_cnt_r <= '0;
      end
      if (in_ch.valid && in_ready) begin
        op_act_r <= action_t'(in_ch.action);
      end
      if (fire) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      op_key_r   <= in_ch.key[KEY_BITS-1:0];
      op_price_r <= in_ch.price_cents;
      op_qty_r   <= in_ch.stock_qty;
      op_pos_r   <= in_ch.position;
    end
    if (fire) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx[IDX_OUT_BITS-1:0];
      out_price_r  <= res_price;
      out_qty_r    <= res_qty;
      out_total_r  <= res_total[TOTAL_BITS-1:0];
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_idx_r;
  assign out_ch.found_price = out_price_r;
  assign out_ch.found_qty   = out_qty_r;
  assign out_ch.entry_total = out_total_r;

  // count stays within the row
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= CAPACITY)
    else $error("entry count beyond capacity");

  // a finished word waits while the result register is occupied
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ch.ready) |=> (state_r == S_FIN))
    else $error("finished word left while result stalled");

  // a good insert grows the list by one
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && op_act_r == ACT_INSERT && !full) |=> (cnt_r == $past(cnt_r) + CNTW'(1)))
    else $error("insert did not bump the count");

  // a new result word only ever comes from the finish step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside the finish step");

endmodule

@@ rtl/klsd_cell.sv @@
module klsd_cell #(
  parameter int CELL_IDX = 0,
  parameter int KEY_BITS = 64,
  parameter int CNTW     = 8
) (
  input  logic                           clk,
  input  klsd_pkg::cell_ctrl_t           ctrl,
  input  logic [KEY_BITS-1:0]            op_key,
  input  logic [klsd_pkg::PRICE_BITS-1:0] op_price,
  input  logic [klsd_pkg::QTY_BITS-1:0]  op_qty,
  input  logic [klsd_pkg::POS_BITS-1:0]  op_pos,
  input  logic [CNTW-1:0]                count,
  input  logic [KEY_BITS-1:0]            nb_key,
  input  logic [klsd_pkg::PRICE_BITS-1:0] nb_price,
  input  logic [klsd_pkg::QTY_BITS-1:0]  nb_qty,
  output logic [KEY_BITS-1:0]            key_r,
  output logic [klsd_pkg::PRICE_BITS-1:0] price_r,
  output logic [klsd_pkg::QTY_BITS-1:0]  qty_r,
  output logic                           hit
);
  import klsd_pkg::*;

  localparam int PW = (CNTW > POS_BITS) ? CNTW : POS_BITS;

  logic [PW-1:0]   my_pos;
  logic [CNTW-1:0] my_idx;
  logic            live;

  assign my_pos = PW'(CELL_IDX);
  assign my_idx = CNTW'(CELL_IDX);
  assign live   = (my_idx < count);

  // insert lands at the fill point, delete pulls from the upper neighbor
  always_ff @(posedge clk) begin
    if (ctrl.wr && (my_idx == count)) begin
      key_r   <= op_key;
      price_r <= op_price;
      qty_r   <= op_qty;
    end else if (ctrl.shift && (my_pos >= PW'(op_pos))) begin
      key_r   <= nb_key;
      price_r <= nb_price;
      qty_r   <= nb_qty;
    end
  end

  assign hit = live && (ctrl.by_key ? (key_r == op_key) : (my_pos == PW'(op_pos)));

endmodule

@@ rtl/klsd_tree.sv @@
module klsd_tree #(
  parameter int CAPACITY = 128,
  parameter int IDXW     = $clog2(CAPACITY)
) (
  input  logic                            clk,
  input  logic [CAPACITY-1:0]             leaf_hit,
  input  logic [klsd_pkg::PRICE_BITS-1:0] leaf_price [CAPACITY],
  input  logic [klsd_pkg::QTY_BITS-1:0]   leaf_qty   [CAPACITY],
  output logic                            root_hit,
  output logic [IDXW-1:0]                 root_idx,
  output logic [klsd_pkg::PRICE_BITS-1:0] root_price,
  output logic [klsd_pkg::QTY_BITS-1:0]   root_qty
);
  import klsd_pkg::*;

  localparam int LEAVES = 1 << IDXW;
  localparam int NODES  = 2 * LEAVES - 1;

  logic                  hit_r   [NODES];
  logic [IDXW-1:0]       idx_r   [NODES];
  logic [PRICE_BITS-1:0] price_r [NODES];
  logic [QTY_BITS-1:0]   qty_r   [NODES];

  // heap layout: node n has children 2n+1 and 2n+2, one register level each
  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
    always_ff @(posedge clk) begin
      if (hit_r[2*n+1]) begin
        hit_r[n]   <= 1'b1;
        idx_r[n]   <= idx_r[2*n+1];
        price_r[n] <= price_r[2*n+1];
        qty_r[n]   <= qty_r[2*n+1];
      end else begin
        hit_r[n]   <= hit_r[2*n+2];
        idx_r[n]   <= idx_r[2*n+2];
        price_r[n] <= price_r[2*n+2];
        qty_r[n]   <= qty_r[2*n+2];
      end
    end
  end

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < CAPACITY) begin : g_used
      always_ff @(posedge clk) begin
        hit_r[LEAVES-1+i]   <= leaf_hit[i];
        idx_r[LEAVES-1+i]   <= IDXW'(i);
        price_r[LEAVES-1+i] <= leaf_price[i];
        qty_r[LEAVES-1+i]   <= leaf_qty[i];
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        hit_r[LEAVES-1+i]   <= 1'b0;
        idx_r[LEAVES-1+i]   <= '0;
        price_r[LEAVES-1+i] <= '0;
        qty_r[LEAVES-1+i]   <= '0;
      end
    end
  end

  assign root_hit   = hit_r[0];
  assign root_idx   = idx_r[0];
  assign root_price = price_r[0];
  assign root_qty   = qty_r[0];

endmodule
